// ----- hw/rtl/packed_pixel_buffer_access_assert.svh -----
// Assertion macros for the packed-pixel buffer access block.
// Each macro expects a clock named clk and an active-high reset named rst in scope.
`ifndef PACKED_PIXEL_BUFFER_ACCESS_ASSERT_SVH
`define PACKED_PIXEL_BUFFER_ACCESS_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define PPBA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define PPBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/ppba_pkg.sv -----
// Package for the packed-pixel buffer access block.
// Holds store geometry, register indexes, the state type and depth helpers; no dependencies.
package ppba_pkg;

  localparam int ROW_BYTES   = 256;
  localparam int MAX_ROWS    = 256;
  localparam int STORE_BYTES = ROW_BYTES * MAX_ROWS;
  localparam int ADDR_W      = $clog2(STORE_BYTES);

  localparam int CFG_DATA_W  = 12;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_BITS_PER_PIXEL = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_ROWS     = 2'd2;

  localparam logic [3:0]  BPP_RESET   = 4'd8;
  localparam logic [11:0] WIDTH_RESET = 12'd2048;
  localparam logic [8:0]  ROWS_RESET  = 9'd256;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_t;

  function automatic logic depth_valid(input logic [3:0] bpp);
    return (bpp == 4'd1) || (bpp == 4'd2) || (bpp == 4'd4) || (bpp == 4'd8);
  endfunction

  function automatic logic [1:0] depth_log2(input logic [3:0] bpp);
    logic [1:0] lg;
    case (bpp)
      4'd2:    lg = 2'd1;
      4'd4:    lg = 2'd2;
      4'd8:    lg = 2'd3;
      default: lg = 2'd0;
    endcase
    return lg;
  endfunction

endpackage

// ----- hw/rtl/packed_pixel_buffer_access.sv -----
// Packed-pixel frame store with single-pixel read and read-modify-write requests.
// Depends on ppba_pkg and packed_pixel_buffer_access_assert.svh.
//
//   channel   signals                                       direction
//   cfg       cfg_write, cfg_index, cfg_data                in, no handshake
//   req       req_valid/req_ready, cmd, pixel_x/y/value    in
//   rsp       rsp_valid/rsp_ready, read_value, out_of_range out
//
// One request per cycle is sustained while rsp_ready is high; a request is registered in
// the modify stage and its result then in the output register, held there until taken.
// The synchronous byte memory (one read and one write port) sets the latency; a
// write followed by a request to the same byte is served by forwarding.
// After reset a clearing pass zeroes all 65536 bytes of the store, with req_ready low.
// A result held in the output register stalls the pipeline only when rsp_ready is low.
`include "packed_pixel_buffer_access_assert.svh"

module packed_pixel_buffer_access (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [ppba_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ppba_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             req_valid,
  output logic                             req_ready,
  input  logic                             cmd,
  input  logic [10:0]                      pixel_x,
  input  logic [7:0]                       pixel_y,
  input  logic [7:0]                       pixel_value,
  output logic                             rsp_valid,
  input  logic                             rsp_ready,
  output logic [7:0]                       read_value,
  output logic                             out_of_range
);

  localparam int AW = ppba_pkg::ADDR_W;

  ppba_pkg::state_t state, state_next;
  logic [AW-1:0] clr_addr;

  logic [3:0]  bits_per_pixel;
  logic [11:0] image_width;
  logic [8:0]  image_rows;

  logic [7:0] mem [ppba_pkg::STORE_BYTES];
  logic [7:0] rdata;

  // Request decode.
  logic          req_fire;
  logic          dec_valid;
  logic [13:0]   dec_bitpos;
  logic [10:0]   dec_col;
  logic          dec_oor;
  logic [AW-1:0] dec_addr;
  logic [2:0]    dec_shift;
  logic [7:0]    dec_mask;
  logic [3:0]    dec_shift_w;

  // Modify stage.
  logic          s1_valid;
  logic          s1_cmd;
  logic          s1_active;
  logic          s1_oor;
  logic [AW-1:0] s1_addr;
  logic [2:0]    s1_shift;
  logic [7:0]    s1_mask;
  logic [7:0]    s1_value;
  logic          s1_adv;
  logic [7:0]    s1_cur;
  logic [7:0]    s1_wdata;
  logic [7:0]    s1_rvalue;
  logic          s1_wr;

  logic          fw_valid;
  logic [AW-1:0] fw_addr;
  logic [7:0]    fw_data;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;

  always_comb begin
    state_next = state;
    case (state)
      ppba_pkg::ST_CLEAR: begin
        if (clr_addr == {AW{1'b1}}) begin
          state_next = ppba_pkg::ST_RUN;
        end
      end
      ppba_pkg::ST_RUN: state_next = ppba_pkg::ST_RUN;
      default:          state_next = ppba_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ppba_pkg::ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ppba_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_per_pixel <= ppba_pkg::BPP_RESET;
      image_width    <= ppba_pkg::WIDTH_RESET;
      image_rows     <= ppba_pkg::ROWS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        ppba_pkg::REG_BITS_PER_PIXEL: bits_per_pixel <= cfg_data[3:0];
        ppba_pkg::REG_IMAGE_WIDTH:    image_width    <= cfg_data[11:0];
        ppba_pkg::REG_IMAGE_ROWS:     image_rows     <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  assign s1_adv    = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = (state == ppba_pkg::ST_RUN) && (!s1_valid || s1_adv);
  assign req_fire  = req_valid && req_ready;

  always_comb begin
    dec_valid   = ppba_pkg::depth_valid(bits_per_pixel);
    dec_bitpos  = dec_valid ? (14'(pixel_x) << ppba_pkg::depth_log2(bits_per_pixel)) : '0;
    dec_col     = dec_bitpos[13:3];
    dec_oor     = (12'(pixel_x) >= image_width) || (9'(pixel_y) >= image_rows) ||
                  (32'(pixel_y) >= 32'(ppba_pkg::MAX_ROWS)) ||
                  (dec_valid && (32'(dec_col) >= 32'(ppba_pkg::ROW_BYTES)));
    dec_addr    = AW'(32'(pixel_y) * 32'(ppba_pkg::ROW_BYTES) + 32'(dec_col));
    dec_shift_w = 4'd8 - bits_per_pixel - {1'b0, dec_bitpos[2:0]};
    dec_shift   = dec_shift_w[2:0];
    dec_mask    = 8'(((9'd1 << bits_per_pixel) - 9'd1) << dec_shift);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      s1_cmd    <= cmd;
      s1_active <= dec_valid && !dec_oor;
      s1_oor    <= dec_oor;
      s1_addr   <= dec_addr;
      s1_shift  <= dec_shift;
      s1_mask   <= dec_mask;
      s1_value  <= pixel_value;
    end
  end

  always_comb begin
    s1_cur    = (fw_valid && (fw_addr == s1_addr)) ? fw_data : rdata;
    s1_wdata  = (s1_cur & ~s1_mask) | ((s1_value << s1_shift) & s1_mask);
    s1_rvalue = (s1_active && (s1_cmd == ppba_pkg::CMD_READ)) ?
                ((s1_cur & s1_mask) >> s1_shift) : 8'd0;
    s1_wr     = s1_adv && s1_active && (s1_cmd == ppba_pkg::CMD_WRITE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fw_valid <= 1'b0;
    end else if (s1_wr) begin
      fw_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_wr) begin
      fw_addr <= s1_addr;
      fw_data <= s1_wdata;
    end
  end

  always_comb begin
    mem_we    = (state == ppba_pkg::ST_CLEAR) || s1_wr;
    mem_waddr = (state == ppba_pkg::ST_CLEAR) ? clr_addr : s1_addr;
    mem_wdata = (state == ppba_pkg::ST_CLEAR) ? 8'd0 : s1_wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (req_fire) begin
      rdata <= mem[dec_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_adv) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      read_value   <= s1_rvalue;
      out_of_range <= s1_oor;
    end
  end

  `PPBA_ASSERT_SAME(a_no_req_while_clearing, req_fire, state == ppba_pkg::ST_RUN,
    "request accepted during the clearing pass")
  `PPBA_ASSERT_SAME(a_no_pixel_write_while_clearing, s1_valid, state == ppba_pkg::ST_RUN,
    "modify stage busy during the clearing pass")
  `PPBA_ASSERT_NEXT(a_stage_feeds_output, s1_adv, rsp_valid,
    "result of the modify stage was not registered")
  `PPBA_ASSERT_SAME(a_flagged_reads_zero, rsp_valid && out_of_range, read_value == 8'd0,
    "flagged request returned a nonzero value")
  `PPBA_ASSERT_NEXT(a_clear_ends, state == ppba_pkg::ST_CLEAR && clr_addr == {AW{1'b1}},
    state == ppba_pkg::ST_RUN, "clearing pass did not end at the last address")

endmodule
